// File: rtl/core/deti_pkg.sv
// shared types and constants for the density/energy table interpolator
`timescale 1ns / 1ps
package deti_pkg;

   localparam int VALUE_W   = 48;
   localparam int ROW_W     = 11;
   localparam int COL_W     = 5;
   localparam int WEIGHT_W  = 17;
   localparam int FRAC_BITS = 16;
   localparam int OUT_LIMIT = 21;
   localparam int CSR_IDX_W = 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1) << FRAC_BITS;
   localparam logic [COL_W-1:0]    COL_DENSITY = COL_W'(0);
   localparam logic [COL_W-1:0]    COL_ENERGY  = COL_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_PER_DENSITY,
      CSR_TOTAL_ROWS,
      CSR_DENSITY_MAX,
      CSR_COLUMN_COUNT
   } csr_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [9:0]                 row_index;
      logic [4:0]                 column_index;
      logic signed [VALUE_W-1:0]  entry_value;
      logic signed [VALUE_W-1:0]  query_density;
      logic signed [VALUE_W-1:0]  query_energy;
   } req_type;

   typedef struct packed {
      logic [4:0]                 result_column;
      logic signed [VALUE_W-1:0]  result_value;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0]           rows_per_density;
      logic [ROW_W-1:0]           total_rows;
      logic signed [VALUE_W-1:0]  density_max;
      logic [COL_W-1:0]           column_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rows_per_density: ROW_W'(2),
      total_rows:       ROW_W'(0),
      density_max:      VALUE_W'(0),
      column_count:     COL_W'(15)
   };

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_DROP,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type kind;
      req_type  req;
   } item_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHK,
      ST_DRD,
      ST_DCMP,
      ST_DLO_RD,
      ST_DLO_WT,
      ST_DDIV,
      ST_EMIN_RD,
      ST_EMAX_RD,
      ST_EMAX_WT,
      ST_ERD,
      ST_ECMP,
      ST_EDIV,
      ST_C0,
      ST_C1,
      ST_C2,
      ST_C3,
      ST_C4,
      ST_M_UP,
      ST_A_UP,
      ST_M_DN,
      ST_A_DN,
      ST_M_FIN,
      ST_A_FIN,
      ST_OUT,
      ST_ZOUT
   } back_state_type;

endpackage

// File: rtl/core/deti_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module deti_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/deti_front.sv
// input queue that classifies each word as load, dropped load or query
`timescale 1ns / 1ps
module deti_front import deti_pkg::*; #(
   parameter int MAX_ROWS = 1024,
   parameter int COLUMNS  = 21
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_data,
   output logic     item_valid,
   input  logic     item_pop,
   output item_type item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       do_push, do_pop;

   always_comb begin
      new_item.req = req_data;
      if (req_data.op == OP_QUERY) begin
         new_item.kind = KIND_QUERY;
      end else if (32'(req_data.row_index) < MAX_ROWS &&
                   32'(req_data.column_index) < COLUMNS) begin
         new_item.kind = KIND_LOAD;
      end else begin
         new_item.kind = KIND_DROP;
      end
   end

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: rtl/core/deti_wdiv.sv
// bit-serial q1.16 weight divider: (v-lo)/(hi-lo), clamped to 0..1
`timescale 1ns / 1ps
module deti_wdiv import deti_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [VALUE_W-1:0]  lo,
   input  logic signed [VALUE_W-1:0]  v,
   input  logic signed [VALUE_W-1:0]  hi,
   output logic                       done,
   output logic [WEIGHT_W-1:0]        q
);

   localparam int REM_W = VALUE_W + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    den_ff, den_in;
   logic [WEIGHT_W-1:0] q_ff, q_in;
   logic [REM_W:0]      rem2;

   assign rem2 = {rem_ff, 1'b0};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         if (v <= lo) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (v >= hi) begin
            q_in    = WEIGHT_ONE;
            done_in = 1'b1;
         end else begin
            rem_in  = REM_W'(v) - REM_W'(lo);
            den_in  = REM_W'(hi) - REM_W'(lo);
            q_in    = '0;
            cnt_in  = CNT_W'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_in = REM_W'(rem2 - {1'b0, den_ff});
            q_in   = {q_ff[WEIGHT_W-2:0], 1'b1};
         end else begin
            rem_in = REM_W'(rem2);
            q_in   = {q_ff[WEIGHT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

// File: rtl/core/deti_back.sv
// sequencer: table writes, density/energy search and per-column blending
`timescale 1ns / 1ps
module deti_back import deti_pkg::*; #(
   parameter int MAX_ROWS = 1024,
   parameter int COLUMNS  = 21
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   output logic     item_pop,
   input  item_type item,
   output logic     out_push,
   input  logic     out_full,
   output rsp_type  out_data
);

   localparam int DEPTH  = MAX_ROWS * COLUMNS;
   localparam int AW     = $clog2(DEPTH);
   localparam int ACC_W  = ROW_W + 1;
   localparam int DIFF_W = VALUE_W + 1;
   localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
   localparam int NMAX   = (COLUMNS < OUT_LIMIT) ? COLUMNS : OUT_LIMIT;

   back_state_type state_ff, state_in;
   logic signed [VALUE_W-1:0] qd_ff, qd_in, qe_ff, qe_in;
   logic [COL_W-1:0]          n_ff, n_in, k_ff, k_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [ROW_W-1:0]          i_ff, i_in, base_ff, base_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [WEIGHT_W-1:0]       wr_ff, wr_in, we_ff, we_in;
   logic signed [VALUE_W-1:0] dhi_ff, dhi_in, emin_ff, emin_in, eprev_ff, eprev_in;
   logic signed [VALUE_W-1:0] xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic signed [VALUE_W-1:0] up_ff, up_in, dn_ff, dn_in, val_ff, val_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   logic [ROW_W-1:0]          rows_r, rows_t, top_row;
   logic [ACC_W-1:0]          next_i;
   logic                      geom_ok;
   logic [ROW_W-1:0]          rd_row;
   logic [COL_W-1:0]          rd_col;
   logic [AW-1:0]             rd_addr, wr_addr;
   logic                      wr_en;
   logic [VALUE_W-1:0]        rd_raw;
   logic signed [VALUE_W-1:0] rd_val;
   logic                      div_start, div_done;
   logic signed [VALUE_W-1:0] div_lo, div_v, div_hi;
   logic [WEIGHT_W-1:0]       div_q;
   logic signed [DIFF_W-1:0]  mul_diff;
   logic [WEIGHT_W-1:0]       mul_w;
   logic signed [VALUE_W-1:0] add_x, blend_res;
   logic                      col_last;

   assign rows_r  = cfg.rows_per_density;
   assign rows_t  = cfg.total_rows;
   assign top_row = base_ff + rows_r - ROW_W'(1);
   assign next_i  = {1'b0, i_ff} + {1'b0, rows_r};
   assign geom_ok = (rows_r >= ROW_W'(2)) && ({rows_r, 1'b0} <= {1'b0, rows_t}) &&
                    (32'(rows_t) <= MAX_ROWS);
   assign rd_val  = signed'(rd_raw);
   assign col_last = (k_ff == n_ff - COL_W'(1));

   assign wr_en   = (state_ff == ST_IDLE) && item_valid && (item.kind == KIND_LOAD);
   assign wr_addr = AW'(32'(item.req.row_index) * COLUMNS + 32'(item.req.column_index));
   assign rd_addr = AW'(32'(rd_row) * COLUMNS + 32'(rd_col));

   deti_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item.req.entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   deti_wdiv u_wdiv (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .lo    (div_lo),
      .v     (div_v),
      .hi    (div_hi),
      .done  (div_done),
      .q     (div_q)
   );

   // shared blend datapath: multiply, register, then floor-shift and add
   always_comb begin
      mul_diff = DIFF_W'(ya_ff) - DIFF_W'(xa_ff);
      mul_w    = we_ff;
      add_x    = xa_ff;
      case (state_ff)
         ST_M_DN: begin
            mul_diff = DIFF_W'(yb_ff) - DIFF_W'(xb_ff);
         end
         ST_M_FIN: begin
            mul_diff = DIFF_W'(up_ff) - DIFF_W'(dn_ff);
            mul_w    = wr_ff;
         end
         ST_A_DN: begin
            add_x = xb_ff;
         end
         ST_A_FIN: begin
            add_x = dn_ff;
         end
         default: begin
         end
      endcase
      prod_in   = PROD_W'(mul_diff) * PROD_W'(signed'({1'b0, mul_w}));
      blend_res = VALUE_W'(PROD_W'(add_x) + (prod_ff >>> FRAC_BITS));
   end

   always_comb begin
      state_in = state_ff;
      qd_in = qd_ff;    qe_in = qe_ff;
      n_in = n_ff;      k_in = k_ff;
      acc_in = acc_ff;  i_in = i_ff;
      base_in = base_ff; lo_in = lo_ff; hi_in = hi_ff;
      wr_in = wr_ff;    we_in = we_ff;
      dhi_in = dhi_ff;  emin_in = emin_ff; eprev_in = eprev_ff;
      xa_in = xa_ff;    ya_in = ya_ff; xb_in = xb_ff; yb_in = yb_ff;
      up_in = up_ff;    dn_in = dn_ff; val_in = val_ff;
      item_pop  = 1'b0;
      out_push  = 1'b0;
      out_data  = '{result_column: k_ff, result_value: val_ff, last: col_last};
      rd_row    = lo_ff;
      rd_col    = k_ff;
      div_start = 1'b0;
      div_lo    = eprev_ff;
      div_v     = qe_ff;
      div_hi    = rd_val;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.kind == KIND_QUERY) begin
                  qd_in  = item.req.query_density;
                  qe_in  = item.req.query_energy;
                  n_in   = (32'(cfg.column_count) > NMAX) ? COL_W'(NMAX) : cfg.column_count;
                  k_in   = '0;
                  acc_in = {1'b0, rows_r};
                  state_in = ST_CHK;
               end
            end
         end
         // total_rows must be a whole number of density blocks
         ST_CHK: begin
            if (!geom_ok) begin
               state_in = ST_ZOUT;
            end else if (acc_ff >= {1'b0, rows_t}) begin
               if (acc_ff != {1'b0, rows_t}) begin
                  state_in = ST_ZOUT;
               end else if (qd_ff <= cfg.density_max) begin
                  i_in     = '0;
                  state_in = ST_DRD;
               end else begin
                  base_in  = rows_t - rows_r;
                  wr_in    = WEIGHT_ONE;
                  state_in = ST_EMIN_RD;
               end
            end else begin
               acc_in = acc_ff + {1'b0, rows_r};
            end
         end
         ST_DRD: begin
            rd_row   = i_ff;
            rd_col   = COL_DENSITY;
            state_in = ST_DCMP;
         end
         ST_DCMP: begin
            if (qd_ff < rd_val) begin
               if (i_ff == '0) begin
                  base_in  = rows_r;
                  wr_in    = '0;
                  state_in = ST_EMIN_RD;
               end else begin
                  base_in  = i_ff;
                  dhi_in   = rd_val;
                  state_in = ST_DLO_RD;
               end
            end else if (next_i >= {1'b0, rows_t}) begin
               base_in  = rows_t - rows_r;
               wr_in    = WEIGHT_ONE;
               state_in = ST_EMIN_RD;
            end else begin
               i_in     = ROW_W'(next_i);
               state_in = ST_DRD;
            end
         end
         ST_DLO_RD: begin
            rd_row   = base_ff - ROW_W'(1);
            rd_col   = COL_DENSITY;
            state_in = ST_DLO_WT;
         end
         ST_DLO_WT: begin
            div_start = 1'b1;
            div_lo    = rd_val;
            div_v     = qd_ff;
            div_hi    = dhi_ff;
            state_in  = ST_DDIV;
         end
         ST_DDIV: begin
            if (div_done) begin
               wr_in    = div_q;
               state_in = ST_EMIN_RD;
            end
         end
         ST_EMIN_RD: begin
            rd_row   = base_ff;
            rd_col   = COL_ENERGY;
            state_in = ST_EMAX_RD;
         end
         ST_EMAX_RD: begin
            rd_row   = top_row;
            rd_col   = COL_ENERGY;
            emin_in  = rd_val;
            state_in = ST_EMAX_WT;
         end
         ST_EMAX_WT: begin
            if (qe_ff <= emin_ff) begin
               lo_in    = base_ff;
               hi_in    = base_ff;
               we_in    = '0;
               state_in = ST_C0;
            end else if (qe_ff < rd_val) begin
               i_in     = base_ff + ROW_W'(1);
               eprev_in = emin_ff;
               state_in = ST_ERD;
            end else begin
               lo_in    = top_row;
               hi_in    = top_row;
               we_in    = WEIGHT_ONE;
               state_in = ST_C0;
            end
         end
         ST_ERD: begin
            rd_row   = i_ff;
            rd_col   = COL_ENERGY;
            state_in = ST_ECMP;
         end
         ST_ECMP: begin
            if (qe_ff < rd_val) begin
               hi_in     = i_ff;
               lo_in     = i_ff - ROW_W'(1);
               div_start = 1'b1;
               state_in  = ST_EDIV;
            end else begin
               eprev_in = rd_val;
               i_in     = i_ff + ROW_W'(1);
               state_in = ST_ERD;
            end
         end
         ST_EDIV: begin
            if (div_done) begin
               we_in    = div_q;
               state_in = ST_C0;
            end
         end
         ST_C0: begin
            rd_row = lo_ff;
            if (n_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_C1;
            end
         end
         ST_C1: begin
            rd_row   = hi_ff;
            xa_in    = rd_val;
            state_in = ST_C2;
         end
         ST_C2: begin
            rd_row   = lo_ff - rows_r;
            ya_in    = rd_val;
            state_in = ST_C3;
         end
         ST_C3: begin
            rd_row   = hi_ff - rows_r;
            xb_in    = rd_val;
            state_in = ST_C4;
         end
         ST_C4: begin
            yb_in    = rd_val;
            state_in = ST_M_UP;
         end
         ST_M_UP:  state_in = ST_A_UP;
         ST_A_UP: begin
            up_in    = blend_res;
            state_in = ST_M_DN;
         end
         ST_M_DN:  state_in = ST_A_DN;
         ST_A_DN: begin
            dn_in    = blend_res;
            state_in = ST_M_FIN;
         end
         ST_M_FIN: state_in = ST_A_FIN;
         ST_A_FIN: begin
            val_in   = blend_res;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + COL_W'(1);
                  state_in = ST_C0;
               end
            end
         end
         // unusable table shape: zeros for every column
         ST_ZOUT: begin
            out_data.result_value = '0;
            if (n_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!out_full) begin
               out_push = 1'b1;
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + COL_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      qd_ff <= qd_in;     qe_ff <= qe_in;
      n_ff <= n_in;       k_ff <= k_in;
      acc_ff <= acc_in;   i_ff <= i_in;
      base_ff <= base_in; lo_ff <= lo_in; hi_ff <= hi_in;
      wr_ff <= wr_in;     we_ff <= we_in;
      dhi_ff <= dhi_in;   emin_ff <= emin_in; eprev_ff <= eprev_in;
      xa_ff <= xa_in;     ya_ff <= ya_in; xb_ff <= xb_in; yb_ff <= yb_in;
      up_ff <= up_in;     dn_ff <= dn_in; val_ff <= val_in;
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/core/deti_out_queue.sv
// small result queue between the sequencer and the rsp port
`timescale 1ns / 1ps
module deti_out_queue import deti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  rsp_type push_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type pop_data
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   rsp_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign count_in = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/density_energy_table_interpolator.sv
// top level: density/energy property table with bilinear interpolation
//
//   port group   direction   handshake          word
//   req_*        in          push / full        req_type (load or query)
//   rsp_*        out         pop / empty        rsp_type (one column result)
//   csr_*        in          valid / ready      index + 48-bit data
//
// a load is written to the table straight from the idle state; a query runs a shape
// check, a scan of the density blocks, up to two divider runs and a scan of the
// energy rows, then works through each column via the table port
// and shared multiplier. the single table read port sets the search time.
// reset is synchronous; the table has no clearing pass and holds garbage until loaded.
// a 2-word input queue and a 4-word result queue let either side stall on its own.
`timescale 1ns / 1ps
module density_energy_table_interpolator import deti_pkg::*; #(
   parameter int MAX_ROWS = 1024,
   parameter int COLUMNS  = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]   csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     item_valid, item_pop;
   item_type item;
   logic     out_push, out_full;
   rsp_type  out_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROWS_PER_DENSITY: cfg_in.rows_per_density = csr_data[ROW_W-1:0];
            CSR_TOTAL_ROWS:       cfg_in.total_rows       = csr_data[ROW_W-1:0];
            CSR_DENSITY_MAX:      cfg_in.density_max      = signed'(csr_data);
            CSR_COLUMN_COUNT:     cfg_in.column_count     = csr_data[COL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   deti_front #(
      .MAX_ROWS (MAX_ROWS),
      .COLUMNS  (COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   deti_back #(
      .MAX_ROWS (MAX_ROWS),
      .COLUMNS  (COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .out_push   (out_push),
      .out_full   (out_full),
      .out_data   (out_data)
   );

   deti_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .full      (out_full),
      .push_data (out_data),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_data)
   );

endmodule

// File: rtl/core/deti_checker.sv
// port-level checks for the interpolator, bound to the top level
`timescale 1ns / 1ps
module deti_checker import deti_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // no query produces more than the column limit, so a non-final word is below it
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.last) |-> (rsp_data.result_column != COL_W'(OUT_LIMIT - 1)))
      else $error("non-final result at the last possible column");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input queue full after reset");

endmodule

bind density_energy_table_interpolator deti_checker u_checker (.*);
